// ===== rtl/core/lbc_pkg.sv =====
package lbc_pkg;

	// Field widths fixed by the interface
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned HOLD_W     = 16;
	localparam int unsigned MAXLEN_W   = 24;
	localparam int unsigned LOOPLEN_W  = 24;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned CFG_IDX_W  = 2;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHECK_PERIOD = 2'd0,
		CFG_LONG_THRESH  = 2'd1,
		CFG_MAX_LOOP_LEN = 2'd2
	} cfg_idx_t;

	// Register reset values
	localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST = 16'd480;
	localparam logic [HOLD_W-1:0]   LONG_THRESH_RST  = 16'd100;
	localparam logic [MAXLEN_W-1:0] MAX_LOOP_LEN_RST = 24'd480000;

	// Event codes reported with each result
	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_LOOP_START = 3'd1,
		EV_LOOP_SET   = 3'd2,
		EV_REC_ON     = 3'd3,
		EV_REC_OFF    = 3'd4,
		EV_CLEARED    = 3'd5
	} event_t;

endpackage

// ===== rtl/core/looper_button_controller_unit.sv =====
// One-button looper controller. One transaction enters per audio sample tick
// carrying the debounced button level, and exactly one result transaction
// leaves for each, in order. On its way from input to result an item is
// captured in an input register, the whole per-tick update (prescaler,
// edge detect, hold and length counters, release decision, clamp against
// max_loop_length) is one short pass of logic, and the result lands in an
// output register. A new item is taken every cycle; throughput is one item
// per clock as long as the result side does not stall. A pending result and
// a captured input can both be held during a stall, so the input side only
// stalls once both are occupied. The button is looked at once every
// check_period ticks (0 behaves as 1); a release after a hold of at least
// long_press_threshold samples clears the loop, a shorter press starts the
// length measurement, ends it (loading the length, clamped, with a flag) or
// toggles recording. All counters saturate. Configuration is written through
// the cfg port (always ready), and should only be written while the block
// is idle.
module looper_button_controller_unit
	import lbc_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// config write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  button_level,

	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  delay_advance,
	output logic                  record_on,
	output logic                  length_load,
	output logic [LOOPLEN_W-1:0]  loop_length,
	output logic                  clear_loop,
	output logic [2:0]            event_code,
	output logic                  length_clamped
);

	// compare width wide enough for both the counter and the max register
	localparam int unsigned CMP_W = (LENGTH_BITS > MAXLEN_W) ? LENGTH_BITS : MAXLEN_W;

	// ---------------- configuration registers ----------------
	logic [PERIOD_W-1:0] check_period_q;
	logic [HOLD_W-1:0]   long_thresh_q;
	logic [MAXLEN_W-1:0] max_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_period_q <= CHECK_PERIOD_RST;
			long_thresh_q  <= LONG_THRESH_RST;
			max_len_q      <= MAX_LOOP_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CHECK_PERIOD: check_period_q <= cfg_data[PERIOD_W-1:0];
				CFG_LONG_THRESH:  long_thresh_q  <= cfg_data[HOLD_W-1:0];
				CFG_MAX_LOOP_LEN: max_len_q      <= cfg_data[MAXLEN_W-1:0];
				default: ;  // unmapped index: write is dropped
			endcase
		end
	end

	// ---------------- handshake ----------------
	logic valid_s1;
	logic button_s1;
	logic out_valid_q;
	logic advance;   // s1 item moves into the result register this cycle

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			button_s1 <= button_level;
		end
	end

	// ---------------- controller state ----------------
	logic [PERIOD_W-1:0]    prescale_q;
	logic                   last_button_q;
	logic [HOLD_W-1:0]      hold_cnt_q;
	logic                   hold_active_q;
	logic [LENGTH_BITS-1:0] len_cnt_q;
	logic                   measuring_q;
	logic                   running_q;
	logic                   loop_defined_q;
	logic                   recording_q;

	// next-state and result values
	logic [PERIOD_W-1:0]    prescale_d;
	logic                   last_button_d;
	logic [HOLD_W-1:0]      hold_cnt_d;
	logic                   hold_active_d;
	logic [LENGTH_BITS-1:0] len_cnt_d;
	logic                   measuring_d;
	logic                   running_d;
	logic                   loop_defined_d;
	logic                   recording_d;
	logic                   load_d;
	logic                   clear_d;
	logic                   clamped_d;
	event_t                 event_d;

	logic [PERIOD_W-1:0]    period_eff;
	logic                   sample_tick;
	logic [CMP_W-1:0]       len_wide;
	logic [CMP_W-1:0]       max_wide;

	assign period_eff  = (check_period_q == '0) ? PERIOD_W'(1) : check_period_q;
	assign sample_tick = (prescale_q >= period_eff);
	assign max_wide    = CMP_W'(max_len_q);

	always_comb begin
		prescale_d     = prescale_q;
		last_button_d  = last_button_q;
		hold_cnt_d     = hold_cnt_q;
		hold_active_d  = hold_active_q;
		len_cnt_d      = len_cnt_q;
		measuring_d    = measuring_q;
		running_d      = running_q;
		loop_defined_d = loop_defined_q;
		recording_d    = recording_q;
		load_d         = 1'b0;
		clear_d        = 1'b0;
		clamped_d      = 1'b0;
		event_d        = EV_NONE;

		// length counter runs while measuring, saturating
		if (measuring_q && (len_cnt_q != '1)) begin
			len_cnt_d = len_cnt_q + LENGTH_BITS'(1);
		end
		len_wide = CMP_W'(len_cnt_d);

		if (sample_tick) begin
			if (button_s1 != last_button_q) begin
				if (button_s1) begin
					// press: start hold count
					hold_cnt_d    = '0;
					hold_active_d = 1'b1;
				end else begin
					// release: decide on held time
					hold_active_d = 1'b0;
					priority if (hold_cnt_q >= long_thresh_q) begin
						len_cnt_d      = '0;
						loop_defined_d = 1'b0;
						recording_d    = 1'b0;
						measuring_d    = 1'b0;
						running_d      = 1'b0;
						clear_d        = 1'b1;
						event_d        = EV_CLEARED;
					end else if (loop_defined_q) begin
						recording_d = !recording_q;
						event_d     = recording_q ? EV_REC_OFF : EV_REC_ON;
					end else if (measuring_q) begin
						measuring_d = 1'b0;
						if (len_wide > max_wide) begin
							len_cnt_d = LENGTH_BITS'(max_wide);
							clamped_d = 1'b1;
						end
						recording_d    = 1'b0;
						loop_defined_d = 1'b1;
						load_d         = 1'b1;
						event_d        = EV_LOOP_SET;
					end else begin
						recording_d = 1'b1;
						measuring_d = 1'b1;
						running_d   = 1'b1;
						event_d     = EV_LOOP_START;
					end
				end
			end
			last_button_d = button_s1;
			// press sample itself counts as one
			if (hold_active_d && (hold_cnt_d != '1)) begin
				hold_cnt_d = hold_cnt_d + HOLD_W'(1);
			end
			prescale_d = PERIOD_W'(1);  // restart, then count this tick
		end else if (prescale_q != '1) begin
			prescale_d = prescale_q + PERIOD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q     <= '0;
			last_button_q  <= 1'b0;
			hold_cnt_q     <= '0;
			hold_active_q  <= 1'b0;
			len_cnt_q      <= '0;
			measuring_q    <= 1'b0;
			running_q      <= 1'b0;
			loop_defined_q <= 1'b0;
			recording_q    <= 1'b0;
		end else if (advance) begin
			prescale_q     <= prescale_d;
			last_button_q  <= last_button_d;
			hold_cnt_q     <= hold_cnt_d;
			hold_active_q  <= hold_active_d;
			len_cnt_q      <= len_cnt_d;
			measuring_q    <= measuring_d;
			running_q      <= running_d;
			loop_defined_q <= loop_defined_d;
			recording_q    <= recording_d;
		end
	end

	// ---------------- result register ----------------
	logic [CMP_W-1:0] len_out_wide;
	assign len_out_wide = CMP_W'(len_cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			delay_advance  <= running_q;   // state before this tick's event
			record_on      <= recording_d;
			length_load    <= load_d;
			loop_length    <= len_out_wide[LOOPLEN_W-1:0];
			clear_loop     <= clear_d;
			event_code     <= event_d;
			length_clamped <= clamped_d;
		end
	end

	// ---------------- assertions ----------------
	// clamp flag only ever rides on a length load
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_clamped |-> length_load && (event_code == EV_LOOP_SET))
		else $error("length_clamped without loop set");

	// a clear leaves recording off
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clear_loop |-> !record_on && (event_code == EV_CLEARED))
		else $error("clear_loop with recording on");

	// measuring always implies the delay line is running and no loop is defined
	assert property (@(posedge clk) disable iff (!arst_n)
		measuring_q |-> running_q && !loop_defined_q)
		else $error("measuring without running delay or with loop defined");

	// an item in s1 that cannot advance keeps the input stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && valid_s1 |=> valid_s1 && out_valid_q)
		else $error("item lost during result stall");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench top for the one-button looper controller.
// Button ticks go in as transactions. Each accepted tick is run through a
// local copy of the controller state and the result is queued. Every result
// transaction is checked field by field against the head of that queue.
module tb_top;
	import lbc_pkg::*;

	localparam int CYCLE_LIMIT    = 600000;
	localparam int HOLDOFF_CYCLES = 60;
	localparam int N_DIR          = 28;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

	// Row kinds of the directed table
	localparam logic ROW_ITEM = 1'b0;
	localparam logic ROW_CFG  = 1'b1;

	typedef struct packed {
		logic                 delay_advance;
		logic                 record_on;
		logic                 length_load;
		logic [LOOPLEN_W-1:0] loop_length;
		logic                 clear_loop;
		event_t               event_code;
		logic                 length_clamped;
	} ctrl_result_t;

	typedef struct packed {
		logic                  kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  lvl;
		logic [7:0]            reps;
		logic                  typed;
		ctrl_result_t          exp;
	} dir_step_t;

	localparam ctrl_result_t ZERO_RES = '0;
	// Long release while the delay line is running
	localparam ctrl_result_t CLEAR_RUN_RES = '{delay_advance: 1'b1, record_on: 1'b0,
		length_load: 1'b0, loop_length: '0, clear_loop: 1'b1, event_code: EV_CLEARED,
		length_clamped: 1'b0};
	// Long release with nothing running
	localparam ctrl_result_t CLEAR_IDLE_RES = '{delay_advance: 1'b0, record_on: 1'b0,
		length_load: 1'b0, loop_length: '0, clear_loop: 1'b1, event_code: EV_CLEARED,
		length_clamped: 1'b0};

	logic clk = 1'b0;
	logic arst_n;

	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic                  in_valid;
	logic                  in_stall;
	logic                  button_level;

	logic                  out_valid;
	logic                  out_stall;
	logic                  delay_advance;
	logic                  record_on;
	logic                  length_load;
	logic [LOOPLEN_W-1:0]  loop_length;
	logic                  clear_loop;
	logic [2:0]            event_code;
	logic                  length_clamped;

	// Controller state as the checker tracks it
	logic [PERIOD_W-1:0]  lp_period;
	logic [HOLD_W-1:0]    lp_thresh;
	logic [MAXLEN_W-1:0]  lp_max_len;
	logic [PERIOD_W-1:0]  lp_prescale;
	logic                 lp_last_btn;
	logic [HOLD_W-1:0]    lp_hold;
	logic                 lp_hold_on;
	logic [LOOPLEN_W-1:0] lp_len;
	logic                 lp_measuring;
	logic                 lp_running;
	logic                 lp_loop_set;
	logic                 lp_rec;

	ctrl_result_t ctrl_expected [$];

	// Directed rows may pin the result instead of taking the prediction
	logic         fixed_exp_on = 1'b0;
	ctrl_result_t fixed_exp = '0;

	logic tx_idle_en = 1'b1;
	logic rx_idle_en = 1'b1;
	int   holdoff_req = 0;

	int errors       = 0;
	int cycle_cnt    = 0;
	int n_ticks      = 0;
	int n_results    = 0;
	int n_writes     = 0;
	int n_in_stalled = 0;
	int n_clamped    = 0;
	int ev_count [8] = '{default: 0};

	dir_step_t dir_tab [N_DIR];

	looper_button_controller_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.button_level   (button_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.delay_advance  (delay_advance),
		.record_on      (record_on),
		.length_load    (length_load),
		.loop_length    (loop_length),
		.clear_loop     (clear_loop),
		.event_code     (event_code),
		.length_clamped (length_clamped)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// One audio tick of the controller. Updates the tracked state and returns
	// the result the block owes for this tick.
	function automatic ctrl_result_t looper_tick(input logic lvl);
		ctrl_result_t r;
		logic [PERIOD_W-1:0] period;
		r = '0;
		period = (lp_period == '0) ? PERIOD_W'(1) : lp_period;
		// advance flag reflects the state before any event of this tick
		r.delay_advance = lp_running;
		if (lp_measuring && lp_len != '1)
			lp_len++;
		if (lp_prescale >= period) begin
			if (lvl != lp_last_btn) begin
				if (lvl) begin
					// press sample restarts the hold count; it is counted below
					lp_hold = '0;
					lp_hold_on = 1'b1;
				end else begin
					lp_hold_on = 1'b0;
					if (lp_hold >= lp_thresh) begin
						// long hold wipes the loop
						lp_len = '0;
						lp_loop_set = 1'b0;
						lp_rec = 1'b0;
						lp_measuring = 1'b0;
						lp_running = 1'b0;
						r.clear_loop = 1'b1;
						r.event_code = EV_CLEARED;
					end else if (lp_loop_set) begin
						lp_rec = !lp_rec;
						r.event_code = lp_rec ? EV_REC_ON : EV_REC_OFF;
					end else if (lp_measuring) begin
						lp_measuring = 1'b0;
						if (lp_len > LOOPLEN_W'(lp_max_len)) begin
							lp_len = LOOPLEN_W'(lp_max_len);
							r.length_clamped = 1'b1;
						end
						lp_rec = 1'b0;
						lp_loop_set = 1'b1;
						r.length_load = 1'b1;
						r.event_code = EV_LOOP_SET;
					end else begin
						// first short press: start measuring, record, run delay
						lp_rec = 1'b1;
						lp_measuring = 1'b1;
						lp_running = 1'b1;
						r.event_code = EV_LOOP_START;
					end
				end
			end
			lp_last_btn = lvl;
			lp_prescale = '0;
			if (lp_hold_on && lp_hold != '1)
				lp_hold++;
		end
		if (lp_prescale != '1)
			lp_prescale++;
		r.record_on = lp_rec;
		r.loop_length = lp_len;
		return r;
	endfunction

	// Monitor: predicts on accepted ticks, checks accepted results, tracks
	// register writes. Everything is sampled at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		ctrl_result_t want;
		ctrl_result_t e;
		if (!arst_n) begin
			lp_period = CHECK_PERIOD_RST;
			lp_thresh = LONG_THRESH_RST;
			lp_max_len = MAX_LOOP_LEN_RST;
			lp_prescale = '0;
			lp_last_btn = 1'b0;
			lp_hold = '0;
			lp_hold_on = 1'b0;
			lp_len = '0;
			lp_measuring = 1'b0;
			lp_running = 1'b0;
			lp_loop_set = 1'b0;
			lp_rec = 1'b0;
			ctrl_expected.delete();
		end else begin
			// result side first: a result never belongs to a tick taken this edge
			if (out_valid && !out_stall) begin
				n_results++;
				if (ctrl_expected.size() == 0) begin
					errors++;
					$display("%0t: result transaction with nothing expected", $time);
				end else begin
					e = ctrl_expected.pop_front();
					if (delay_advance !== e.delay_advance) begin
						errors++;
						$display("%0t: delay_advance expected %0d got %0d",
							$time, e.delay_advance, delay_advance);
					end
					if (record_on !== e.record_on) begin
						errors++;
						$display("%0t: record_on expected %0d got %0d",
							$time, e.record_on, record_on);
					end
					if (length_load !== e.length_load) begin
						errors++;
						$display("%0t: length_load expected %0d got %0d",
							$time, e.length_load, length_load);
					end
					if (loop_length !== e.loop_length) begin
						errors++;
						$display("%0t: loop_length expected %0d got %0d",
							$time, e.loop_length, loop_length);
					end
					if (clear_loop !== e.clear_loop) begin
						errors++;
						$display("%0t: clear_loop expected %0d got %0d",
							$time, e.clear_loop, clear_loop);
					end
					if (event_code !== e.event_code) begin
						errors++;
						$display("%0t: event_code expected %0d got %0d",
							$time, e.event_code, event_code);
					end
					if (length_clamped !== e.length_clamped) begin
						errors++;
						$display("%0t: length_clamped expected %0d got %0d",
							$time, e.length_clamped, length_clamped);
					end
					ev_count[e.event_code]++;
					if (e.length_clamped)
						n_clamped++;
				end
			end
			if (in_valid && !in_stall) begin
				want = looper_tick(button_level);
				if (fixed_exp_on)
					want = fixed_exp;
				ctrl_expected.push_back(want);
				n_ticks++;
			end
			if (in_valid && in_stall)
				n_in_stalled++;
			if (cfg_valid && cfg_ready) begin
				n_writes++;
				case (cfg_index)
					CFG_CHECK_PERIOD: lp_period = cfg_data[PERIOD_W-1:0];
					CFG_LONG_THRESH:  lp_thresh = cfg_data[HOLD_W-1:0];
					CFG_MAX_LOOP_LEN: lp_max_len = cfg_data[MAXLEN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time,
				ctrl_expected.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold-off
	// on request so the block backs up into its input.
	initial begin
		int stall_left;
		int holds_done;
		stall_left = 0;
		holds_done = 0;
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (holdoff_req > holds_done) begin
				holds_done++;
				stall_left = HOLDOFF_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 9);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one tick transaction and returns right after the edge that took
	// it. Whoever runs next drives in_valid at the following falling edge.
	task automatic send_item(input logic lvl, input logic typed, input ctrl_result_t exp);
		@(negedge clk);
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		fixed_exp_on = typed;
		fixed_exp = exp;
		in_valid <= 1'b1;
		button_level <= lvl;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering ticks and wait until every result has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ctrl_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		drain_results();
		// margin for the two-stage pipe to settle
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Button gestures in units of samples: mostly short presses (start, set,
	// record toggles), some long ones (clear), some raw noise.
	task automatic press_gestures(input int n_items, input int per, input int thr);
		int done_items;
		int k;
		int gap;
		int r;
		done_items = 0;
		while (done_items < n_items) begin
			r = $urandom_range(0, 9);
			if (r < 8) begin
				if (r < 7 && thr > 1)
					k = $urandom_range(1, thr - 1);
				else
					k = $urandom_range(thr > 0 ? thr : 1, thr + 3);
				gap = $urandom_range(1, 8);
				repeat (k * per) send_item(1'b1, 1'b0, ZERO_RES);
				repeat (gap * per) send_item(1'b0, 1'b0, ZERO_RES);
				done_items += (k + gap) * per;
			end else begin
				k = $urandom_range(1, 8);
				repeat (k) send_item(1'($urandom_range(0, 1)), 1'b0, ZERO_RES);
				done_items += k;
			end
		end
	endtask

	initial begin
		int per;
		int thr;
		int max_len;

		in_valid <= 1'b0;
		button_level <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_CHECK_PERIOD;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// kind, reg, data, level, repeats, pinned, pinned result
		dir_tab = '{
			// reset defaults: prescaler far from its first sampling
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b0, 8'd1, 1'b1, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b1, 8'd3, 1'b1, ZERO_RES},
			// period dropped below the running count: one sampling, press
			'{ROW_CFG,  CFG_CHECK_PERIOD, 24'd2, 1'b0, 8'd0, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b1, 8'd1, 1'b0, ZERO_RES},
			// zero period samples every tick; junk above the 16-bit threshold
			'{ROW_CFG,  CFG_CHECK_PERIOD, 24'd0, 1'b0, 8'd0, 1'b0, ZERO_RES},
			'{ROW_CFG,  CFG_LONG_THRESH, 24'hAB0003, 1'b0, 8'd0, 1'b0, ZERO_RES},
			'{ROW_CFG,  CFG_MAX_LOOP_LEN, 24'd2, 1'b0, 8'd0, 1'b0, ZERO_RES},
			// start, measure, set with clamp, record on, record off
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b0, 8'd1, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b0, 8'd3, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b1, 8'd1, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b0, 8'd1, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b1, 8'd1, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b0, 8'd1, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b1, 8'd1, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b0, 8'd1, 1'b0, ZERO_RES},
			// hold right at the threshold, then release: clear
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b1, 8'd3, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b0, 8'd1, 1'b1, CLEAR_RUN_RES},
			// zero threshold: any release is long
			'{ROW_CFG,  CFG_LONG_THRESH, 24'd0, 1'b0, 8'd0, 1'b0, ZERO_RES},
			'{ROW_CFG,  CFG_MAX_LOOP_LEN, 24'd0, 1'b0, 8'd0, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b1, 8'd1, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b0, 8'd1, 1'b1, CLEAR_IDLE_RES},
			// top values, and a write to the unused index that must do nothing
			'{ROW_CFG,  CFG_LONG_THRESH, 24'h00FFFF, 1'b0, 8'd0, 1'b0, ZERO_RES},
			'{ROW_CFG,  CFG_MAX_LOOP_LEN, 24'hFFFFFF, 1'b0, 8'd0, 1'b0, ZERO_RES},
			'{ROW_CFG,  CFG_IDX_UNUSED, 24'h5A5A5A, 1'b0, 8'd0, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b1, 8'd1, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b0, 8'd1, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b1, 8'd1, 1'b0, ZERO_RES},
			'{ROW_ITEM, CFG_CHECK_PERIOD, 24'd0, 1'b0, 8'd1, 1'b0, ZERO_RES}
		};

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_tab[i].kind == ROW_CFG)
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			else
				repeat (dir_tab[i].reps) send_item(dir_tab[i].lvl, dir_tab[i].typed,
					dir_tab[i].exp);
		end

		// Random phases, each under its own register setting
		for (int p = 0; p < 9; p++) begin
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			per = $urandom_range(1, 4);
			thr = $urandom_range(2, 8);
			max_len = $urandom_range(1, 40);
			case (p)
				0: begin per = 1; thr = 4; max_len = 24'hFFFFFF; end
				1: begin per = 2; thr = 3; max_len = 0; end
				2: begin per = 0; thr = 1; max_len = 5; end
				3: per = 65535;
				default: ;
			endcase
			write_reg(CFG_CHECK_PERIOD, {8'($urandom), 16'(per)});
			write_reg(CFG_LONG_THRESH, {8'($urandom), 16'(thr)});
			write_reg(CFG_MAX_LOOP_LEN, 24'(max_len));
			case (p)
				2: press_gestures(40, 1, thr);
				// slowest sampling: the prescaler never gets there
				3: repeat (30) send_item(1'($urandom_range(0, 1)), 1'b0, ZERO_RES);
				// result side holds off while ticks keep coming
				5: begin
					tx_idle_en = 1'b0;
					holdoff_req++;
					press_gestures(100, per, thr);
				end
				// sender pauses mid-phase until everything is back
				6: begin
					press_gestures(40, per, thr);
					drain_results();
					press_gestures(40, per, thr);
				end
				default: press_gestures(80, per, thr);
			endcase
		end

		// Last stretch runs with no idling on either side
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		write_reg(CFG_CHECK_PERIOD, {8'($urandom), 16'($urandom_range(1, 3))});
		write_reg(CFG_LONG_THRESH, {8'($urandom), 16'd5});
		write_reg(CFG_MAX_LOOP_LEN, 24'($urandom_range(1, 40)));
		press_gestures(100, 1, 5);

		drain_results();
		repeat (10) @(negedge clk);

		$display("Covered %0d ticks, %0d results, %0d register writes, %0d stalled offers;",
			n_ticks, n_results, n_writes, n_in_stalled);
		$display("  events: start %0d set %0d (clamped %0d) on %0d off %0d clear %0d",
			ev_count[EV_LOOP_START], ev_count[EV_LOOP_SET], n_clamped,
			ev_count[EV_REC_ON], ev_count[EV_REC_OFF], ev_count[EV_CLEARED]);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
